// File: design/bit_field_copy_engine_core_macros.svh
// Assertion macros shared by the checker of the bit field copy engine.
// Expects clk and arst_n in the scope of use.
`ifndef BIT_FIELD_COPY_ENGINE_CORE_MACROS_SVH
`define BIT_FIELD_COPY_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define BFCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bfce_pkg.sv
// Types and constants of the bit field copy engine.
// No dependencies.
package bfce_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_COPY  = 2'd2;

	localparam logic [1:0] RD_ADDR = 2'd0;
	localparam logic [1:0] RD_SRC  = 2'd1;
	localparam logic [1:0] RD_DST  = 2'd2;

	localparam int ADDR_MAX = 4095;
	localparam int STEP_W   = 4;

	typedef struct packed {
		logic       load;
		logic       red_step;
		logic       load_ptr;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic       wr_copy;
		logic       latch_src;
		logic       advance;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       red_last;
		logic       count_zero;
		logic       last_chunk;
	} dp_stat_t;

	// compare-subtract steps that fold a 12-bit address into the memory size
	function automatic int red_steps(input int mem);
		int k;
		k = 0;
		while ((mem << k) <= ADDR_MAX) k++;
		return k;
	endfunction

endpackage

// File: design/bfce_if.sv
// Word channels of the bit field copy engine: request and response.
// No dependencies.
interface bfce_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [11:0] address;
	logic [7:0]  write_data;
	logic [11:0] source_address;
	logic [2:0]  source_bit;
	logic [11:0] target_address;
	logic [2:0]  target_bit;
	logic [15:0] bit_count;

	modport source (output valid, command, address, write_data, source_address, source_bit,
		target_address, target_bit, bit_count, input ready);
	modport sink (input valid, command, address, write_data, source_address, source_bit,
		target_address, target_bit, bit_count, output ready);
endinterface

interface bfce_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] completed_command;

	modport source (output valid, read_data, completed_command, input ready);
	modport sink (input valid, read_data, completed_command, output ready);
endinterface

// File: design/bfce_dp.sv
// Datapath: byte memory, address folding, chunk merge and copy pointers.
// Depends on bfce_pkg.
module bfce_dp import bfce_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic        clk,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  command,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic [11:0] source_address,
	input  logic [2:0]  source_bit,
	input  logic [11:0] target_address,
	input  logic [2:0]  target_bit,
	input  logic [15:0] bit_count,
	output logic [7:0]  read_data,
	output logic [1:0]  completed_command
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RED_STEPS = red_steps(MEM_BYTES);
	localparam logic [12:0] DIV = 13'(MEM_BYTES);
	localparam logic [STEP_W-1:0] LAST_K = STEP_W'(RED_STEPS - 1);
	localparam logic [AW-1:0] TOP_ADDR = AW'(MEM_BYTES - 1);

	logic [7:0]        mem_q [MEM_BYTES];
	logic [7:0]        rdata_q;
	logic [1:0]        cmd_q;
	logic [11:0]       a_q, sa_q, ta_q;
	logic [7:0]        wd_q, src_q;
	logic [2:0]        so_q, to_q;
	logic [15:0]       cnt_q;
	logic [AW-1:0]     sp_q, dp_q;
	logic [STEP_W-1:0] red_k_q;

	logic [12:0]   div_k;
	logic [2:0]    hi;
	logic [3:0]    avail, n;
	logic [7:0]    chunk, mask, merged, wdata;
	logic [3:0]    s_sum, d_sum;
	logic [AW-1:0] raddr, waddr, sp_nx, dp_nx;

	function automatic logic [11:0] fold(input logic [11:0] v, input logic [12:0] d);
		return ({1'b0, v} >= d) ? 12'({1'b0, v} - d) : v;
	endfunction

	assign div_k = DIV << (LAST_K - red_k_q);

	assign hi     = (so_q > to_q) ? so_q : to_q;
	assign avail  = 4'd8 - {1'b0, hi};
	assign n      = (cnt_q < {12'd0, avail}) ? cnt_q[3:0] : avail;
	assign chunk  = 8'(src_q << so_q) >> to_q;
	assign mask   = 8'(8'hFF << (4'd8 - n)) >> to_q;
	assign merged = (rdata_q & ~mask) | (chunk & mask);
	assign s_sum  = {1'b0, so_q} + n;
	assign d_sum  = {1'b0, to_q} + n;
	assign sp_nx  = (sp_q == TOP_ADDR) ? '0 : sp_q + AW'(1);
	assign dp_nx  = (dp_q == TOP_ADDR) ? '0 : dp_q + AW'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_SRC:  raddr = sp_q;
			RD_DST:  raddr = dp_q;
			default: raddr = AW'(a_q);
		endcase
		waddr = cmd.wr_copy ? dp_q : AW'(a_q);
		wdata = cmd.wr_copy ? merged : wd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			a_q     <= address;
			wd_q    <= write_data;
			sa_q    <= source_address;
			so_q    <= source_bit;
			ta_q    <= target_address;
			to_q    <= target_bit;
			cnt_q   <= bit_count;
			red_k_q <= '0;
		end else if (cmd.red_step) begin
			a_q     <= fold(a_q, div_k);
			sa_q    <= fold(sa_q, div_k);
			ta_q    <= fold(ta_q, div_k);
			red_k_q <= red_k_q + STEP_W'(1);
		end else if (cmd.advance) begin
			so_q  <= s_sum[2:0];
			to_q  <= d_sum[2:0];
			cnt_q <= cnt_q - {12'd0, n};
			if (s_sum[3]) begin
				sp_q <= sp_nx;
			end
			if (d_sum[3]) begin
				dp_q <= dp_nx;
			end
		end
		if (cmd.load_ptr) begin
			sp_q <= AW'(sa_q);
			dp_q <= AW'(ta_q);
		end
		if (cmd.latch_src) begin
			src_q <= rdata_q;
		end
	end

	assign stat.command    = cmd_q;
	assign stat.red_last   = (red_k_q == LAST_K);
	assign stat.count_zero = (cnt_q == 16'd0);
	assign stat.last_chunk = (cnt_q == {12'd0, n});

	assign read_data         = (cmd_q == CMD_READ) ? rdata_q : 8'd0;
	assign completed_command = cmd_q;

endmodule

// File: design/bfce_ctrl.sv
// Controller: sequences folding, byte access and chunked copy, owns handshakes.
// Depends on bfce_pkg.
module bfce_ctrl import bfce_pkg::*; #(
	parameter int RED_STEPS = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_CSRC = 3'd3;
	localparam logic [2:0] S_CDST = 3'd4;
	localparam logic [2:0] S_CWR  = 3'd5;
	localparam logic [2:0] S_RESP = 3'd6;

	logic [2:0] state_q, state_nx;

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		cmd.rd_sel = RD_ADDR;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = (RED_STEPS > 0) ? S_RED : S_EXEC;
				end
			end
			S_RED: begin
				cmd.red_step = 1'b1;
				if (stat.red_last) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.load_ptr = 1'b1;
				case (stat.command)
					CMD_WRITE: begin
						cmd.wr_en = 1'b1;
						state_nx  = S_RESP;
					end
					CMD_READ: begin
						cmd.rd_en = 1'b1;
						state_nx  = S_RESP;
					end
					CMD_COPY: begin
						state_nx = stat.count_zero ? S_RESP : S_CSRC;
					end
					default: begin
						state_nx = S_RESP;
					end
				endcase
			end
			S_CSRC: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SRC;
				state_nx   = S_CDST;
			end
			S_CDST: begin
				cmd.latch_src = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_DST;
				state_nx      = S_CWR;
			end
			S_CWR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_copy = 1'b1;
				cmd.advance = 1'b1;
				state_nx    = stat.last_chunk ? S_RESP : S_CSRC;
			end
			S_RESP: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// File: design/bit_field_copy_engine_core.sv
// From accept to response the controller runs R address folding steps (R is 0 when
// MEM_BYTES >= 4096), an execute step that writes or reads the byte or loads the copy
// pointers, and for a copy C chunks, each one source read, one target read and one
// target write of the memory; the response is then held until taken. One command in
// flight: the next word is accepted at the earliest in the cycle after the response is
// taken. Reset returns the controller to idle; memory contents are not cleared.
module bit_field_copy_engine_core import bfce_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input logic       clk,
	input logic       arst_n,
	bfce_req_if.sink   req,
	bfce_rsp_if.source rsp
);

	localparam int RED_STEPS = red_steps(MEM_BYTES);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bfce_ctrl #(.RED_STEPS(RED_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bfce_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk               (clk),
		.cmd               (cmd),
		.stat              (stat),
		.command           (req.command),
		.address           (req.address),
		.write_data        (req.write_data),
		.source_address    (req.source_address),
		.source_bit        (req.source_bit),
		.target_address    (req.target_address),
		.target_bit        (req.target_bit),
		.bit_count         (req.bit_count),
		.read_data         (rsp.read_data),
		.completed_command (rsp.completed_command)
	);

endmodule

// File: design/bfce_chk.sv
// Port-level checker for the bit field copy engine, bound to the top level.
// Depends on bfce_pkg and bit_field_copy_engine_core_macros.svh.
`include "bit_field_copy_engine_core_macros.svh"

module bfce_chk import bfce_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_data,
	input logic [1:0] completed_command
);

	`BFCE_ASSERT_NXT(a_no_rsp_after_accept, req_valid && req_ready, !rsp_valid, "rsp right after accept")
	`BFCE_ASSERT_IMP(a_one_in_flight, rsp_valid, !req_ready, "ready while response pending")
	`BFCE_ASSERT_IMP(a_rdata_zero, rsp_valid && (completed_command != CMD_READ), read_data == 8'd0, "nonzero read data")
	`BFCE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(completed_command), "response dropped")

endmodule

bind bit_field_copy_engine_core bfce_chk u_bfce_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.read_data         (rsp.read_data),
	.completed_command (rsp.completed_command)
);

// File: sim/tb_bit_field_copy_engine_core.sv
// Testbench for bit_field_copy_engine_core: byte writes, byte reads, MSB-first bit copies and unused commands.
// A shadow byte image predicts every response word. Depends on bfce_pkg and bfce_if.
module tb_bit_field_copy_engine_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bfce_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int MEM_SIZE = 4096;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PRINT_LIMIT = 40;
	localparam logic [11:0] WIN_BASE = 12'd3990;
	localparam int WIN_BYTES = 240;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] command;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	bfce_req_if req_if ();
	bfce_rsp_if rsp_if ();

	bit_field_copy_engine_core #(.MEM_BYTES(MEM_SIZE)) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	logic [7:0]  byte_image [MEM_SIZE];
	bit          byte_known [MEM_SIZE];
	logic [11:0] known_addrs [$];
	rsp_word_t   rsp_expected [$];

	int send_idle_pct;
	int rcv_idle_pct;
	int hold_left;
	int mismatches;
	int cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycles, rsp_expected.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// response side: a long hold-off while hold_left runs, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		rsp_word_t w;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (rsp_expected.size() == 0) begin
				report_mismatch("response word with none pending", rsp_if.completed_command, 0);
			end else begin
				w = rsp_expected.pop_front();
				if (rsp_if.completed_command !== w.command)
					report_mismatch("completed_command", rsp_if.completed_command, w.command);
				if (rsp_if.read_data !== w.read_data)
					report_mismatch("read_data", rsp_if.read_data, w.read_data);
			end
		end
	end

	// random traffic stays in a window across the wrap point
	function automatic logic [11:0] win_addr();
		return WIN_BASE + 12'($urandom_range(WIN_BYTES - 1));
	endfunction

	// ascending chunked copy, MSB-first bit numbering, addresses wrap at 4096
	function automatic void shadow_copy(input logic [11:0] sa, input logic [2:0] sb,
		input logic [11:0] ta, input logic [2:0] tb, input logic [15:0] cnt);
		int unsigned so, to, left, n;
		logic [7:0] shifted, chunk, mask;
		so = sb;
		to = tb;
		left = cnt;
		while (left > 0) begin
			n = 8 - ((so > to) ? so : to);
			if (n > left)
				n = left;
			shifted = byte_image[sa] << so;
			chunk = shifted >> to;
			mask = 8'hFF << (8 - n);
			mask = mask >> to;
			byte_image[ta] = (byte_image[ta] & ~mask) | (chunk & mask);
			so += n;
			to += n;
			if (so >= 8) begin
				sa = sa + 12'd1;
				so -= 8;
			end
			if (to >= 8) begin
				ta = ta + 12'd1;
				to -= 8;
			end
			left -= n;
		end
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [11:0] addr,
		input logic [7:0] data, input logic [11:0] sa, input logic [2:0] sb,
		input logic [11:0] ta, input logic [2:0] tb, input logic [15:0] cnt);
		rsp_word_t w;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.command <= cmd;
		req_if.address <= addr;
		req_if.write_data <= data;
		req_if.source_address <= sa;
		req_if.source_bit <= sb;
		req_if.target_address <= ta;
		req_if.target_bit <= tb;
		req_if.bit_count <= cnt;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		w.read_data = 8'h00;
		w.command = cmd;
		case (cmd)
			CMD_WRITE: begin
				byte_image[addr] = data;
				if (!byte_known[addr]) begin
					byte_known[addr] = 1'b1;
					known_addrs.push_back(addr);
				end
			end
			CMD_READ: w.read_data = byte_image[addr];
			CMD_COPY: shadow_copy(sa, sb, ta, tb, cnt);
			default: ;
		endcase
		rsp_expected.push_back(w);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (rsp_expected.size() != 0);
	endtask

	task automatic do_write(input logic [11:0] addr, input logic [7:0] data);
		send_word(CMD_WRITE, addr, data, 12'($urandom), 3'($urandom), 12'($urandom),
			3'($urandom), 16'($urandom));
	endtask

	// never reads a byte that has not been written
	task automatic do_read(input logic [11:0] addr);
		if (!byte_known[addr])
			addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
		send_word(CMD_READ, addr, 8'($urandom), 12'($urandom), 3'($urandom), 12'($urandom),
			3'($urandom), 16'($urandom));
	endtask

	// fill unwritten bytes that a copy will touch
	task automatic cover_span(input logic [11:0] start, input logic [2:0] off,
		input logic [15:0] cnt);
		int unsigned nbytes;
		logic [11:0] a;
		if (cnt == 0)
			return;
		nbytes = (off + cnt - 1) / 8 + 1;
		if (nbytes > MEM_SIZE)
			nbytes = MEM_SIZE;
		for (int unsigned i = 0; i < nbytes; i++) begin
			a = start + 12'(i);
			if (!byte_known[a])
				do_write(a, 8'($urandom));
		end
	endtask

	task automatic do_copy(input logic [11:0] sa, input logic [2:0] sb,
		input logic [11:0] ta, input logic [2:0] tb, input logic [15:0] cnt);
		cover_span(sa, sb, cnt);
		cover_span(ta, tb, cnt);
		send_word(CMD_COPY, 12'($urandom), 8'($urandom), sa, sb, ta, tb, cnt);
	endtask

	task automatic test_byte_access();
		do_write(12'd0, 8'h00);
		do_write(12'd4095, 8'hFF);
		do_write(12'd1, 8'hA5);
		do_write(12'd2048, 8'h5A);
		do_read(12'd0);
		do_read(12'd4095);
		do_read(12'd1);
		do_read(12'd2048);
	endtask

	task automatic test_copy_edges();
		do_copy(12'($urandom), 3'($urandom), 12'($urandom), 3'($urandom), 16'd0);
		do_copy(12'd1, 3'd7, 12'd0, 3'd0, 16'd1);
		do_copy(12'd2048, 3'd0, 12'd300, 3'd0, 16'd8);
		do_copy(12'd300, 3'd7, 12'd310, 3'd3, 16'd13);
		// overlap, target ahead of source: later chunks see rewritten bytes
		do_copy(12'd100, 3'd0, 12'd100, 3'd3, 16'd20);
		// overlap, target behind source
		do_copy(12'd101, 3'd2, 12'd100, 3'd0, 16'd24);
		// runs past the last byte and wraps to byte 0
		do_copy(12'd4094, 3'd5, 12'd500, 3'd1, 16'd30);
		do_copy(12'd10, 3'd0, 12'd4095, 3'd6, 16'd20);
		send_word(CMD_UNUSED, 12'hFFF, 8'hFF, 12'hFFF, 3'd7, 12'hFFF, 3'd7, 16'hFFFF);
		do_read(12'd100);
		do_read(12'd101);
		do_read(12'd0);
		do_read(12'd4095);
	endtask

	task automatic test_long_copies();
		do_copy(12'd0, 3'd0, 12'd60, 3'd0, 16'd512);
		do_copy(12'd7, 3'd3, 12'd8, 3'd5, 16'd1000);
		do_copy(12'd4000, 3'd1, 12'd3990, 3'd0, 16'd1200);
		do_read(12'd3990);
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		do_write(12'($urandom), 8'($urandom));
		do_read(12'($urandom));
		do_copy(12'($urandom), 3'($urandom), 12'($urandom), 3'($urandom),
			16'($urandom_range(40)));
		do_write(12'($urandom), 8'($urandom));
		do_read(12'($urandom));
		wait_drained();
		do_copy(12'($urandom), 3'($urandom), 12'($urandom), 3'($urandom),
			16'($urandom_range(40)));
		do_read(12'($urandom));
	endtask

	task automatic test_random(input int n);
		int pick;
		logic [11:0] sa, ta;
		logic [15:0] cnt;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				do_write(win_addr(), 8'($urandom));
			end else if (pick < 65) begin
				do_read(win_addr());
			end else if (pick < 96) begin
				sa = win_addr();
				if ($urandom_range(99) < 30)
					ta = sa + 12'($urandom_range(8)) - 12'd4;
				else
					ta = win_addr();
				pick = $urandom_range(99);
				if (pick < 10)
					cnt = 16'd0;
				else if (pick < 75)
					cnt = 16'($urandom_range(24, 1));
				else
					cnt = 16'($urandom_range(200, 25));
				do_copy(sa, 3'($urandom), ta, 3'($urandom), cnt);
			end else begin
				send_word(CMD_UNUSED, 12'($urandom), 8'($urandom), 12'($urandom),
					3'($urandom), 12'($urandom), 3'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.command = CMD_WRITE;
		req_if.address = '0;
		req_if.write_data = '0;
		req_if.source_address = '0;
		req_if.source_bit = '0;
		req_if.target_address = '0;
		req_if.target_bit = '0;
		req_if.bit_count = '0;
		rsp_if.ready = 1'b0;
		hold_left = 0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 16;
		rcv_idle_pct = 53;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_byte_access();
		test_copy_edges();
		test_long_copies();
		test_random(330);
		wait_drained();

		send_idle_pct = 53;
		rcv_idle_pct = 16;
		test_backpressure();
		test_random(330);
		wait_drained();

		send_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random(300);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && rsp_expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
